/* rtl/indexed_list_store_macros.svh */
// Assertion macros for the indexed list store checker.
// Used by ils_checker.sv only; no other dependencies.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define ILS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ILS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the indexed list store.
// No dependencies; used by every module of the block.
package ils_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int GRP_SIZE     = 16;   // cells per registered read group

    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 7;
    localparam int CMP_W  = 9;          // holds any position or count

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [VAL_W-1:0] MISS_WORD = '1;

    // Word bit layout on the stream ports
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Broadcast to every cell in the accept cycle
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* rtl/ils_cell.sv */
`timescale 1ns / 1ps
// One list slot: holds an entry and shifts with its neighbors.
// Depends on ils_pkg.
module ils_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          aclk,
    input  ils_pkg::cell_ctrl_t           ctrl,
    input  logic [ils_pkg::VAL_W-1:0]     left_in,   // entry of slot CELL_IDX-1
    input  logic [ils_pkg::VAL_W-1:0]     right_in,  // entry of slot CELL_IDX+1
    input  logic [ils_pkg::CMP_W-1:0]     rd_pos,
    output logic [ils_pkg::VAL_W-1:0]     value_out,
    output logic [ils_pkg::VAL_W-1:0]     rd_masked
);

    localparam logic [ils_pkg::CMP_W-1:0] MY_IDX = ils_pkg::CMP_W'(CELL_IDX);

    logic [ils_pkg::VAL_W-1:0] value_reg;
    logic [ils_pkg::VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.ins) begin
            if (MY_IDX > ctrl.pos) begin
                value_next = left_in;
            end else if (MY_IDX == ctrl.pos) begin
                value_next = ctrl.value;
            end
        end else if (ctrl.del) begin
            if (MY_IDX >= ctrl.pos) begin
                value_next = right_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;
    assign rd_masked = (MY_IDX == rd_pos) ? value_reg : '0;

endmodule

/* rtl/ils_chain.sv */
`timescale 1ns / 1ps
// Row of list cells plus the registered group stage of the read path.
// Depends on ils_pkg and ils_cell.
module ils_chain #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          cap_en,  // word accepted this cycle
    input  ils_pkg::cell_ctrl_t           ctrl,
    input  logic [ils_pkg::CMP_W-1:0]     rd_pos,
    output logic [ils_pkg::VAL_W-1:0]     rd_word  // OR of groups, valid cycle after cap_en
);

    localparam int NGRP = (CAPACITY + ils_pkg::GRP_SIZE - 1) / ils_pkg::GRP_SIZE;

    logic [ils_pkg::VAL_W-1:0] cell_val  [CAPACITY];
    logic [ils_pkg::VAL_W-1:0] cell_mask [CAPACITY];
    logic [ils_pkg::VAL_W-1:0] grp_reg   [NGRP];
    logic [ils_pkg::VAL_W-1:0] grp_next  [NGRP];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ils_pkg::VAL_W-1:0] left_w;
        logic [ils_pkg::VAL_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_val[i+1];
        end
        ils_cell #(.CELL_IDX(i)) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .left_in   (left_w),
            .right_in  (right_w),
            .rd_pos    (rd_pos),
            .value_out (cell_val[i]),
            .rd_masked (cell_mask[i])
        );
    end

    // First level: OR within each group of cells, registered
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < ils_pkg::GRP_SIZE; j++) begin
                if (g * ils_pkg::GRP_SIZE + j < CAPACITY) begin
                    grp_next[g] = grp_next[g] | cell_mask[g * ils_pkg::GRP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_en) begin
            grp_reg <= grp_next;
        end
    end

    // Second level: OR across the groups
    always_comb begin
        rd_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_word = rd_word | grp_reg[g];
        end
    end

endmodule

/* rtl/indexed_list_store.sv */
`timescale 1ns / 1ps
// Top level of the indexed list store: stream ports, count and result path.
// Depends on ils_pkg and ils_chain (which holds the ils_cell row).
//
// Usage
//   s_ channel: one word per operation (read, insert head, insert tail,
//   insert at index, delete at index). m_ channel: exactly one result word
//   per input word, in order: read data (-1 unless a read hit), status
//   (done / out of range / full) and the list length after the operation.
//   Every cell compares its slot number with the index and shifts with its
//   neighbors in the accept cycle, so list updates take effect at once.
//   A result reaches m_tvalid through the work stage and the output register;
//   the read path goes through a registered group-OR stage and the output
//   register. Throughput: one word per cycle while m_tready stays high.
//   Reset (aresetn low, synchronous) empties the list and drops any
//   in-flight result; entry contents are not cleared, and only entries
//   below the count are ever read. When the receiver stalls the result
//   holds in the output register, one more result waits in the work stage,
//   and s_tready drops until the work stage can move on.
module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] operation, [10:3] position, [42:11] item_value, [47:43] zero
    input  logic [ils_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_data, [33:32] status, [40:34] list_length, [47:41] zero
    output logic [ils_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [ils_pkg::CMP_W-1:0] CAP_C = ils_pkg::CMP_W'(CAPACITY);

    // Input word fields
    logic [ils_pkg::OP_W-1:0]  op;
    logic [ils_pkg::POS_W-1:0] pos;
    logic [ils_pkg::VAL_W-1:0] val;
    assign op  = s_tdata[2:0];
    assign pos = s_tdata[10:3];
    assign val = s_tdata[42:11];

    logic                      acc;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ils_pkg::CMP_W-1:0] cnt_c, pos_c;
    logic                      full;

    // Work stage: status and length of the accepted word, read pending
    logic                      w_valid_reg;
    logic                      w_hit_reg, w_hit_next;
    logic [ils_pkg::ST_W-1:0]  w_status_reg, w_status_next;
    logic [ils_pkg::LEN_W-1:0] w_len_reg;
    logic                      w_move;

    // Output register
    logic                         m_valid_reg;
    logic [ils_pkg::M_TDATA_W-1:0] m_data_reg;

    ils_pkg::cell_ctrl_t       ctrl;
    logic [ils_pkg::VAL_W-1:0] rd_word;
    logic [ils_pkg::VAL_W-1:0] rd_data;

    assign w_move   = w_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !w_valid_reg || w_move;
    assign acc      = s_tvalid && s_tready;

    assign cnt_c = ils_pkg::CMP_W'(count_reg);
    assign pos_c = ils_pkg::CMP_W'(pos);
    assign full  = (cnt_c == CAP_C);

    // Decode: shift control for the cells, status, next count
    always_comb begin
        ctrl.ins      = 1'b0;
        ctrl.del      = 1'b0;
        ctrl.pos      = pos_c;
        ctrl.value    = val;
        w_hit_next    = 1'b0;
        w_status_next = ils_pkg::ST_DONE;
        count_next    = count_reg;
        case (op)
            ils_pkg::OP_READ: begin
                if (pos_c < cnt_c) begin
                    w_hit_next = 1'b1;
                end else begin
                    w_status_next = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_INS_HEAD: begin
                ctrl.pos = '0;
                if (full) begin
                    w_status_next = ils_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            ils_pkg::OP_INS_TAIL: begin
                ctrl.pos = cnt_c;
                if (full) begin
                    w_status_next = ils_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            ils_pkg::OP_INS_AT: begin
                // range check ranks ahead of the full check
                if (pos_c > cnt_c) begin
                    w_status_next = ils_pkg::ST_RANGE;
                end else if (full) begin
                    w_status_next = ils_pkg::ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (pos_c >= cnt_c) begin
                    w_status_next = ils_pkg::ST_RANGE;
                end else begin
                    ctrl.del = 1'b1;
                end
            end
            default: begin
                w_status_next = ils_pkg::ST_RANGE;
            end
        endcase
        if (!acc) begin
            ctrl.ins = 1'b0;
            ctrl.del = 1'b0;
        end
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    ils_chain #(.CAPACITY(CAPACITY)) u_chain (
        .aclk    (aclk),
        .cap_en  (acc),
        .ctrl    (ctrl),
        .rd_pos  (pos_c),
        .rd_word (rd_word)
    );

    assign rd_data = w_hit_reg ? rd_word : ils_pkg::MISS_WORD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            w_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (acc) begin
                w_valid_reg <= 1'b1;
            end else if (w_move) begin
                w_valid_reg <= 1'b0;
            end
            if (w_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            w_hit_reg    <= w_hit_next;
            w_status_reg <= w_status_next;
            w_len_reg    <= ils_pkg::LEN_W'(count_next);
        end
        if (w_move) begin
            m_data_reg <= {7'd0, w_len_reg, w_status_reg, rd_data};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/ils_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the result channel of the indexed list store.
// Depends on ils_pkg and indexed_list_store_macros.svh; bound to indexed_list_store.
`include "indexed_list_store_macros.svh"

module ils_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ils_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word stays put
    `ILS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // Status code 3 is never produced
    `ILS_ASSERT(a_status, m_tvalid |-> m_tdata[33:32] != 2'd3, "undefined status code")

    // Any failed operation reports the miss word
    `ILS_ASSERT(a_miss, m_tvalid && m_tdata[33:32] != ils_pkg::ST_DONE |-> m_tdata[31:0] == ils_pkg::MISS_WORD, "failed operation without miss word")

    // No result shows in the cycle after a reset edge
    `ILS_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
